### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, empty when synthesising.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_HOLDS(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
    else $error("invariant violated");

`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("implication violated");

`else

`define ASSERT_HOLDS(lbl, clk, rstn, expr)

`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)

`endif

`endif

### rtl/core/fre_pkg.sv
// ----------------------------------------------------------------------------
// fre_pkg
// Shared types and constants of the framebuffer fill engine.
// ----------------------------------------------------------------------------
package fre_pkg;

  localparam logic [1:0] OP_PIXEL = 2'd0;
  localparam logic [1:0] OP_RECT  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_TICK  = 2'd3;

  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_FB_BASE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCR_WIDTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCR_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH     = 3'd4;

  localparam logic [5:0] DEPTH_32 = 6'd32;
  localparam logic [5:0] DEPTH_24 = 6'd24;

  typedef struct packed {
    logic [31:0] fb_base;
    logic [13:0] screen_width;
    logic [13:0] screen_height;
    logic [15:0] line_pitch;
    logic [5:0]  pixel_depth;
  } cfg_t;

  typedef struct packed {
    logic        linear;
    logic [13:0] col;
    logic [13:0] line;
    logic [27:0] pos;
    logic [31:0] color;
    logic        last;
  } qent_t;

endpackage

### rtl/core/fre_front.sv
// ----------------------------------------------------------------------------
// fre_front
// Takes command and tick words, loads the walk counters and issues one
// queue entry per tick while a command is running.
// ----------------------------------------------------------------------------
module fre_front (
  input  logic                clk,
  input  logic                rst_n,
  input  fre_pkg::cfg_t       cfg,
  input  logic                in_acc,
  input  logic [1:0]          in_op,
  input  logic [12:0]         in_pos_x,
  input  logic [12:0]         in_pos_y,
  input  logic [13:0]         in_rect_w,
  input  logic [13:0]         in_rect_h,
  input  logic [31:0]         in_fill_color,
  output logic                push,
  output fre_pkg::qent_t      push_entry,
  output logic                active
);

  logic        active_r, active_nxt;
  logic        linear_r, linear_nxt;
  logic [13:0] col_r, col_nxt;
  logic [13:0] line_r, line_nxt;
  logic [13:0] first_col_r, first_col_nxt;
  logic [13:0] end_col_r, end_col_nxt;
  logic [13:0] end_line_r, end_line_nxt;
  logic [27:0] count_r, count_nxt;
  logic [27:0] pos_r, pos_nxt;
  logic [31:0] color_r, color_nxt;

  logic [13:0] ld_x, ld_y, ld_w, ld_h;
  logic [14:0] sum_x, sum_y;
  logic [13:0] clip_w, clip_h;
  logic        rect_ok, cmd_linear, fb_on;
  logic [27:0] lin_total;
  logic [14:0] next_col, next_line;
  logic        col_wrap, line_done, lin_last, tick_last;

  always_comb begin
    ld_x = '0;
    ld_y = '0;
    ld_w = 14'd1;
    ld_h = 14'd1;
    unique case (in_op)
      fre_pkg::OP_PIXEL: begin
        ld_x = {1'b0, in_pos_x};
        ld_y = {1'b0, in_pos_y};
      end
      fre_pkg::OP_RECT: begin
        ld_x = {1'b0, in_pos_x};
        ld_y = {1'b0, in_pos_y};
        ld_w = in_rect_w;
        ld_h = in_rect_h;
      end
      fre_pkg::OP_CLEAR: begin
        ld_w = cfg.screen_width;
        ld_h = cfg.screen_height;
      end
      default: ;
    endcase
  end

  assign fb_on      = cfg.fb_base != 32'd0;
  assign sum_x      = {1'b0, ld_x} + {1'b0, ld_w};
  assign sum_y      = {1'b0, ld_y} + {1'b0, ld_h};
  assign clip_w     = (sum_x > {1'b0, cfg.screen_width}) ? (cfg.screen_width - ld_x) : ld_w;
  assign clip_h     = (sum_y > {1'b0, cfg.screen_height}) ? (cfg.screen_height - ld_y) : ld_h;
  assign rect_ok    = fb_on && (ld_x < cfg.screen_width) && (ld_y < cfg.screen_height) &&
                      (clip_w != 14'd0) && (clip_h != 14'd0);
  assign cmd_linear = (in_op == fre_pkg::OP_CLEAR) && (cfg.pixel_depth == fre_pkg::DEPTH_32);
  assign lin_total  = 28'(cfg.screen_width) * 28'(cfg.screen_height);

  assign next_col  = {1'b0, col_r} + 15'd1;
  assign next_line = {1'b0, line_r} + 15'd1;
  assign col_wrap  = next_col >= {1'b0, end_col_r};
  assign line_done = col_wrap && (next_line >= {1'b0, end_line_r});
  assign lin_last  = count_r == 28'd1;
  assign tick_last = linear_r ? lin_last : line_done;

  always_comb begin
    active_nxt    = active_r;
    linear_nxt    = linear_r;
    col_nxt       = col_r;
    line_nxt      = line_r;
    first_col_nxt = first_col_r;
    end_col_nxt   = end_col_r;
    end_line_nxt  = end_line_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    color_nxt     = color_r;
    push          = 1'b0;
    if (in_acc && (in_op != fre_pkg::OP_TICK) && !active_r) begin
      color_nxt = in_fill_color;
      if (cmd_linear) begin
        if (fb_on) begin
          linear_nxt = 1'b1;
          count_nxt  = lin_total;
          pos_nxt    = '0;
          active_nxt = lin_total != 28'd0;
        end
      end else if (rect_ok) begin
        linear_nxt    = 1'b0;
        first_col_nxt = ld_x;
        col_nxt       = ld_x;
        line_nxt      = ld_y;
        end_col_nxt   = 14'(ld_x + clip_w);
        end_line_nxt  = 14'(ld_y + clip_h);
        active_nxt    = 1'b1;
      end
    end else if (in_acc && (in_op == fre_pkg::OP_TICK) && active_r) begin
      push = 1'b1;
      if (linear_r) begin
        pos_nxt   = pos_r + 28'd1;
        count_nxt = count_r - 28'd1;
        if (lin_last) begin
          active_nxt = 1'b0;
        end
      end else if (col_wrap) begin
        col_nxt  = first_col_r;
        line_nxt = next_line[13:0];
        if (line_done) begin
          active_nxt = 1'b0;
        end
      end else begin
        col_nxt = next_col[13:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      linear_r    <= 1'b0;
      col_r       <= '0;
      line_r      <= '0;
      first_col_r <= '0;
      end_col_r   <= '0;
      end_line_r  <= '0;
      count_r     <= '0;
      pos_r       <= '0;
      color_r     <= '0;
    end else begin
      active_r    <= active_nxt;
      linear_r    <= linear_nxt;
      col_r       <= col_nxt;
      line_r      <= line_nxt;
      first_col_r <= first_col_nxt;
      end_col_r   <= end_col_nxt;
      end_line_r  <= end_line_nxt;
      count_r     <= count_nxt;
      pos_r       <= pos_nxt;
      color_r     <= color_nxt;
    end
  end

  always_comb begin
    push_entry.linear = linear_r;
    push_entry.col    = col_r;
    push_entry.line   = line_r;
    push_entry.pos    = pos_r;
    push_entry.color  = color_r;
    push_entry.last   = tick_last;
  end

  assign active = active_r;

endmodule

### rtl/core/fre_queue.sv
// ----------------------------------------------------------------------------
// fre_queue
// Small first-in first-out buffer between the front and the back end.
// ----------------------------------------------------------------------------
module fre_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  fre_pkg::qent_t  push_data,
  input  logic            pop,
  output fre_pkg::qent_t  pop_data,
  output logic            not_empty,
  output logic            full
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  fre_pkg::qent_t   slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = count_r == CNT_W'(DEPTH);
  assign not_empty = count_r != '0;
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data = slot_r[rd_ptr_r];

endmodule

### rtl/core/fre_back.sv
// ----------------------------------------------------------------------------
// fre_back
// Address pipeline: forms offsets and bounds, checks the pixel and drives
// the write word from an output register.
// ----------------------------------------------------------------------------
module fre_back (
  input  logic            clk,
  input  logic            rst_n,
  input  fre_pkg::cfg_t   cfg,
  input  logic            q_not_empty,
  input  fre_pkg::qent_t  q_entry,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            out_write_valid,
  output logic [32:0]     out_write_addr,
  output logic [31:0]     out_write_data,
  output logic            out_write_size,
  output logic            out_write_last,
  output logic            out_busy_res
);

  typedef struct packed {
    logic        linear;
    logic        lin_ok;
    logic [32:0] lin_addr;
    logic        in_scr;
    logic [31:0] base;
    logic [29:0] line_off;
    logic [16:0] col_off;
    logic [29:0] lim;
    logic [2:0]  bpp;
    logic        is32;
    logic        is24;
    logic [31:0] color;
    logic        last;
  } s1_t;

  logic        s1_v_r, s1_v_nxt;
  s1_t         s1_r, s1_nxt;
  logic        out_v_r, out_v_nxt;
  logic        wv_r, wv_nxt;
  logic [32:0] wa_r, wa_nxt;
  logic [31:0] wd_r, wd_nxt;
  logic        ws_r, ws_nxt;
  logic        wl_r, wl_nxt;

  logic        out_ready, s1_ready;
  logic [30:0] idx;
  logic [31:0] idx_end;
  logic        fits, walk_ok;
  logic [32:0] walk_addr;

  assign out_ready = !out_v_r || !out_stall;
  assign s1_ready  = !s1_v_r || out_ready;
  assign q_pop     = q_not_empty && s1_ready;
  assign s1_v_nxt  = s1_ready ? q_not_empty : s1_v_r;
  assign out_v_nxt = out_ready ? s1_v_r : out_v_r;

  always_comb begin
    s1_nxt.linear   = q_entry.linear;
    s1_nxt.lin_ok   = cfg.fb_base != 32'd0;
    s1_nxt.lin_addr = {1'b0, cfg.fb_base} + {3'b000, q_entry.pos, 2'b00};
    s1_nxt.in_scr   = (cfg.fb_base != 32'd0) && (q_entry.col < cfg.screen_width) &&
                      (q_entry.line < cfg.screen_height);
    s1_nxt.base     = cfg.fb_base;
    s1_nxt.bpp      = cfg.pixel_depth[5:3];
    s1_nxt.line_off = 30'(q_entry.line) * 30'(cfg.line_pitch);
    s1_nxt.col_off  = 17'(q_entry.col) * 17'(cfg.pixel_depth[5:3]);
    s1_nxt.lim      = 30'(cfg.screen_height) * 30'(cfg.line_pitch);
    s1_nxt.is32     = cfg.pixel_depth == fre_pkg::DEPTH_32;
    s1_nxt.is24     = cfg.pixel_depth == fre_pkg::DEPTH_24;
    s1_nxt.color    = q_entry.color;
    s1_nxt.last     = q_entry.last;
  end

  assign idx       = {1'b0, s1_r.line_off} + {14'd0, s1_r.col_off};
  assign idx_end   = {1'b0, idx} + {29'd0, s1_r.bpp};
  assign fits      = ({1'b0, idx} < {2'b00, s1_r.lim}) && (idx_end <= {2'b00, s1_r.lim});
  assign walk_ok   = s1_r.in_scr && fits && (s1_r.is32 || s1_r.is24);
  assign walk_addr = {1'b0, s1_r.base} + {2'b00, idx};

  always_comb begin
    wv_nxt = 1'b0;
    wa_nxt = '0;
    wd_nxt = '0;
    ws_nxt = 1'b0;
    wl_nxt = s1_r.last;
    if (s1_r.linear) begin
      if (s1_r.lin_ok) begin
        wv_nxt = 1'b1;
        wa_nxt = s1_r.lin_addr;
        wd_nxt = s1_r.color;
      end
    end else if (walk_ok) begin
      wv_nxt = 1'b1;
      wa_nxt = walk_addr;
      wd_nxt = s1_r.is32 ? s1_r.color : {8'h00, s1_r.color[23:0]};
      ws_nxt = !s1_r.is32;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_r <= s1_nxt;
    end
    if (out_ready && s1_v_r) begin
      wv_r <= wv_nxt;
      wa_r <= wa_nxt;
      wd_r <= wd_nxt;
      ws_r <= ws_nxt;
      wl_r <= wl_nxt;
    end
  end

  assign out_valid       = out_v_r;
  assign out_write_valid = wv_r;
  assign out_write_addr  = wa_r;
  assign out_write_data  = wd_r;
  assign out_write_size  = ws_r;
  assign out_write_last  = wl_r;
  assign out_busy_res    = !wl_r;

endmodule

### rtl/core/framebuffer_rect_fill_engine.sv
// ----------------------------------------------------------------------------
// framebuffer_rect_fill_engine
// Top level of the framebuffer fill engine.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries command and tick words. A
//   pixel, rectangle or clear command is acted on only while no command runs;
//   it produces no output word. Each tick while a command runs produces one
//   output word describing a memory write (or a skipped pixel with
//   out_write_valid low and zeroed address, data and size).
//   Output channel (out_valid / out_stall) carries the write words;
//   out_write_last marks the final word of a command, out_busy_res is its
//   complement.
//   A tick's word passes the queue, the address stage and output register.
//   Throughput: one tick per cycle unless stalled (single multiply stage).
//   A FIFO_DEPTH entry queue sits between the counter front end and the
//   address pipeline; when the receiver stalls, the output register holds,
//   the pipeline and queue fill, and in_stall rises once the queue is full.
//   Configuration is written through cfg_we / cfg_index / cfg_wdata; the
//   user must write it only while idle, which the block does not enforce.
//   Reset zeroes the control and configuration registers; the engine idles.
// ----------------------------------------------------------------------------
module framebuffer_rect_fill_engine #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [fre_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_op,
  input  logic [12:0]                    in_pos_x,
  input  logic [12:0]                    in_pos_y,
  input  logic [13:0]                    in_rect_w,
  input  logic [13:0]                    in_rect_h,
  input  logic [31:0]                    in_fill_color,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_write_valid,
  output logic [32:0]                    out_write_addr,
  output logic [31:0]                    out_write_data,
  output logic                           out_write_size,
  output logic                           out_write_last,
  output logic                           out_busy_res
);

  `include "assert_macros.svh"

  fre_pkg::cfg_t  cfg_r, cfg_nxt;
  fre_pkg::qent_t push_entry, pop_entry;
  logic           in_acc, push, pop, q_not_empty, q_full, front_active;
  logic           skip_zero;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        fre_pkg::CFG_FB_BASE:    cfg_nxt.fb_base       = cfg_wdata;
        fre_pkg::CFG_SCR_WIDTH:  cfg_nxt.screen_width  = cfg_wdata[13:0];
        fre_pkg::CFG_SCR_HEIGHT: cfg_nxt.screen_height = cfg_wdata[13:0];
        fre_pkg::CFG_PITCH:      cfg_nxt.line_pitch    = cfg_wdata[15:0];
        fre_pkg::CFG_DEPTH:      cfg_nxt.pixel_depth   = cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_stall = q_full;
  assign in_acc   = in_valid && !in_stall;

  fre_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_acc        (in_acc),
    .in_op         (in_op),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_rect_w     (in_rect_w),
    .in_rect_h     (in_rect_h),
    .in_fill_color (in_fill_color),
    .push          (push),
    .push_entry    (push_entry),
    .active        (front_active)
  );

  fre_queue #(
    .DEPTH (FIFO_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_entry),
    .pop       (pop),
    .pop_data  (pop_entry),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  fre_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_not_empty     (q_not_empty),
    .q_entry         (pop_entry),
    .q_pop           (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_write_valid (out_write_valid),
    .out_write_addr  (out_write_addr),
    .out_write_data  (out_write_data),
    .out_write_size  (out_write_size),
    .out_write_last  (out_write_last),
    .out_busy_res    (out_busy_res)
  );

  assign skip_zero = (out_write_addr == 33'd0) && (out_write_data == 32'd0) &&
                     !out_write_size;

  `ASSERT_IMPLIES(a_push_needs_active, clk, rst_n, push, front_active)
  `ASSERT_IMPLIES(a_skip_zeroed, clk, rst_n, out_valid && !out_write_valid, skip_zero)
  `ASSERT_IMPLIES(a_three_byte_data, clk, rst_n, out_valid && out_write_valid && out_write_size, out_write_data[31:24] == 8'h00)

endmodule
